FILE: design/rob_pkg.sv
`default_nettype none

package rob_pkg;

    // field widths
    localparam int COORD_W   = 21;
    localparam int VEC_W     = 16;
    localparam int T_W       = 32;
    localparam int EPS_W     = 15;
    localparam int BASIS_W   = 3 * VEC_W;
    localparam int CFG_W     = 3 * COORD_W;
    localparam int CFG_IDX_W = 3;

    // geometry
    localparam int NUM_AXES  = 3;
    localparam int NUM_FACES = 2 * NUM_AXES;
    localparam int FRAC_SH   = 14;

    // internal arithmetic widths
    localparam int REL_W   = COORD_W + 1;
    localparam int PPROD_W = VEC_W + REL_W;
    localparam int DPROD_W = 2 * VEC_W;
    localparam int POS_W   = PPROD_W + 2;
    localparam int DIRP_W  = DPROD_W + 2;
    localparam int DIFF_W  = POS_W + 1;
    localparam int DIVN_W  = DIFF_W + FRAC_SH;
    localparam int Q_W     = T_W - 1;
    localparam int CMP_W   = DIRP_W + Q_W;
    localparam int DIV_STAGES = Q_W + 1;
    localparam int T_LO_W  = 16;
    localparam int T_HI_W  = Q_W - T_LO_W;
    localparam int PLO_W   = DIRP_W + T_LO_W + 1;
    localparam int PHI_W   = DIRP_W + T_HI_W + 1;
    localparam int U_W     = PHI_W + T_LO_W + 1;

    // register reset values
    localparam logic [BASIS_W-1:0] E1_RST  = 48'h0000_0000_4000;
    localparam logic [BASIS_W-1:0] E2_RST  = 48'h0000_4000_0000;
    localparam logic [BASIS_W-1:0] E3_RST  = 48'h4000_0000_0000;
    localparam logic [EPS_W-1:0]   EPS_RST = 15'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_E1     = 3'd0,
        CFG_E2     = 3'd1,
        CFG_E3     = 3'd2,
        CFG_ORIGIN = 3'd3,
        CFG_SIZE   = 3'd4,
        CFG_EPS    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][BASIS_W-1:0] basis;
        logic [CFG_W-1:0]                 origin;
        logic [CFG_W-1:0]                 size;
        logic [EPS_W-1:0]                 eps;
    } cfg_t;

    // data that travels beside the dividers
    typedef struct packed {
        logic [NUM_AXES-1:0][POS_W-1:0]  pos;
        logic [NUM_AXES-1:0][DIRP_W-1:0] dir;
        logic [NUM_FACES-1:0]            elig;
        logic [T_W-1:0]                  tmin;
        logic [T_W-1:0]                  tmax;
    } side_t;

    // divider operands, magnitudes
    typedef struct packed {
        logic [NUM_FACES-1:0][DIVN_W-1:0] num;
        logic [NUM_AXES-1:0][DIRP_W-1:0]  den;
    } divop_t;

endpackage

`default_nettype wire

FILE: design/rob_project.sv
`default_nettype none

module rob_project (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   en,
    input  logic                                                   in_valid,
    input  logic [rob_pkg::NUM_AXES-1:0][rob_pkg::COORD_W-1:0]     ray_origin,
    input  logic [rob_pkg::NUM_AXES-1:0][rob_pkg::VEC_W-1:0]       ray_dir,
    input  logic [rob_pkg::T_W-1:0]                                tmin,
    input  logic [rob_pkg::T_W-1:0]                                tmax,
    input  rob_pkg::cfg_t                                          cfg,
    output logic                                                   out_valid,
    output rob_pkg::side_t                                         side,
    output rob_pkg::divop_t                                        divop
);

    localparam int STAGES = 4;
    localparam int NA = rob_pkg::NUM_AXES;

    logic [STAGES-1:0] valid_reg;
    logic [rob_pkg::T_W-1:0] tmin_reg [STAGES-1];
    logic [rob_pkg::T_W-1:0] tmax_reg [STAGES-1];

    logic signed [rob_pkg::REL_W-1:0]   rel_next [NA];
    logic signed [rob_pkg::REL_W-1:0]   rel_reg  [NA];
    logic signed [rob_pkg::VEC_W-1:0]   rd_reg   [NA];
    logic signed [rob_pkg::PPROD_W-1:0] pp_next  [NA][NA];
    logic signed [rob_pkg::PPROD_W-1:0] pp_reg   [NA][NA];
    logic signed [rob_pkg::DPROD_W-1:0] dp_next  [NA][NA];
    logic signed [rob_pkg::DPROD_W-1:0] dp_reg   [NA][NA];
    logic signed [rob_pkg::POS_W-1:0]   pos_next [NA];
    logic signed [rob_pkg::POS_W-1:0]   pos_reg  [NA];
    logic signed [rob_pkg::DIRP_W-1:0]  dir_next [NA];
    logic signed [rob_pkg::DIRP_W-1:0]  dir_reg  [NA];
    logic [rob_pkg::DIRP_W-1:0]         ad       [NA];
    logic                               axis_ok  [NA];
    logic signed [rob_pkg::DIFF_W-1:0]  diff     [rob_pkg::NUM_FACES];
    logic [rob_pkg::DIFF_W-1:0]         mag      [rob_pkg::NUM_FACES];
    rob_pkg::side_t  side_next, side_reg;
    rob_pkg::divop_t divop_next, divop_reg;

    // valid bits travel with the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // stage 1: position relative to the box corner
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            rel_next[i] = rob_pkg::REL_W'($signed(ray_origin[i]))
                - rob_pkg::REL_W'($signed(cfg.origin[i*rob_pkg::COORD_W +: rob_pkg::COORD_W]));
        end
    end

    // stage 2: component products of the dot products
    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            for (int i = 0; i < NA; i++)
            begin
                pp_next[k][i] = rob_pkg::PPROD_W'($signed(
                        cfg.basis[k][i*rob_pkg::VEC_W +: rob_pkg::VEC_W]))
                    * rob_pkg::PPROD_W'(rel_reg[i]);
                dp_next[k][i] = rob_pkg::DPROD_W'($signed(
                        cfg.basis[k][i*rob_pkg::VEC_W +: rob_pkg::VEC_W]))
                    * rob_pkg::DPROD_W'(rd_reg[i]);
            end
        end
    end

    // stage 3: sums into box coordinates
    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            pos_next[k] = rob_pkg::POS_W'(pp_reg[k][0]) + rob_pkg::POS_W'(pp_reg[k][1])
                + rob_pkg::POS_W'(pp_reg[k][2]);
            dir_next[k] = rob_pkg::DIRP_W'(dp_reg[k][0]) + rob_pkg::DIRP_W'(dp_reg[k][1])
                + rob_pkg::DIRP_W'(dp_reg[k][2]);
        end
    end

    // stage 4: parallel test, face numerators and sign check
    always_comb
    begin
        side_next  = '0;
        divop_next = '0;
        for (int k = 0; k < NA; k++)
        begin
            ad[k] = dir_reg[k][rob_pkg::DIRP_W-1] ? rob_pkg::DIRP_W'(-dir_reg[k])
                                                  : rob_pkg::DIRP_W'(dir_reg[k]);
            axis_ok[k] = ad[k] > (rob_pkg::DIRP_W'(cfg.eps) << rob_pkg::FRAC_SH);
            side_next.pos[k]  = pos_reg[k];
            side_next.dir[k]  = dir_reg[k];
            divop_next.den[k] = ad[k];
            for (int f = 0; f < 2; f++)
            begin
                diff[2*k+f] = (f == 1)
                    ? ((rob_pkg::DIFF_W'($signed(
                        cfg.size[k*rob_pkg::COORD_W +: rob_pkg::COORD_W])) <<< rob_pkg::FRAC_SH)
                        - rob_pkg::DIFF_W'(pos_reg[k]))
                    : -rob_pkg::DIFF_W'(pos_reg[k]);
                mag[2*k+f] = diff[2*k+f][rob_pkg::DIFF_W-1] ? rob_pkg::DIFF_W'(-diff[2*k+f])
                                                            : rob_pkg::DIFF_W'(diff[2*k+f]);
                side_next.elig[2*k+f] = axis_ok[k] && (diff[2*k+f] != '0)
                    && (diff[2*k+f][rob_pkg::DIFF_W-1] == dir_reg[k][rob_pkg::DIRP_W-1]);
                divop_next.num[2*k+f] = rob_pkg::DIVN_W'(mag[2*k+f]) << rob_pkg::FRAC_SH;
            end
        end
        side_next.tmin = tmin_reg[STAGES-2];
        side_next.tmax = tmax_reg[STAGES-2];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rel_reg     <= rel_next;
            pp_reg      <= pp_next;
            dp_reg      <= dp_next;
            pos_reg     <= pos_next;
            dir_reg     <= dir_next;
            side_reg    <= side_next;
            divop_reg   <= divop_next;
            tmin_reg[0] <= tmin;
            tmax_reg[0] <= tmax;
            for (int s = 1; s < STAGES - 1; s++)
            begin
                tmin_reg[s] <= tmin_reg[s-1];
                tmax_reg[s] <= tmax_reg[s-1];
            end
            for (int i = 0; i < NA; i++)
            begin
                rd_reg[i] <= $signed(ray_dir[i]);
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign side      = side_reg;
    assign divop     = divop_reg;

endmodule

`default_nettype wire

FILE: design/rob_div.sv
`default_nettype none

module rob_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rob_pkg::DIVN_W-1:0]  num,
    input  logic [rob_pkg::DIRP_W-1:0]  den,
    output logic [rob_pkg::Q_W-1:0]     quo
);

    localparam int NS = rob_pkg::DIV_STAGES;

    logic [rob_pkg::DIVN_W-1:0] rem_reg [NS];
    logic [rob_pkg::DIRP_W-1:0] den_reg [NS];
    logic [rob_pkg::Q_W-1:0]    q_reg   [NS];
    logic                       ovf_reg [NS];

    // first stage: quotient too large for the range saturates
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= rob_pkg::CMP_W'(num)
                >= (rob_pkg::CMP_W'(den) << rob_pkg::Q_W);
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 1; s < NS; s++)
    begin : g_step
        localparam int J = rob_pkg::Q_W - s;
        logic [rob_pkg::CMP_W-1:0]  shifted;
        logic                       take;
        logic [rob_pkg::DIVN_W-1:0] rem_next;
        logic [rob_pkg::Q_W-1:0]    q_next;

        always_comb
        begin
            shifted  = rob_pkg::CMP_W'(den_reg[s-1]) << J;
            take     = rob_pkg::CMP_W'(rem_reg[s-1]) >= shifted;
            rem_next = take ? rob_pkg::DIVN_W'(rob_pkg::CMP_W'(rem_reg[s-1]) - shifted)
                            : rem_reg[s-1];
            q_next   = q_reg[s-1];
            q_next[J] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ovf_reg[s] <= ovf_reg[s-1];
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_reg[s-1];
                q_reg[s]   <= q_next;
            end
        end
    end

    assign quo = ovf_reg[NS-1] ? '1 : q_reg[NS-1];

endmodule

`default_nettype wire

FILE: design/rob_check.sv
`default_nettype none

module rob_check (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 en,
    input  logic                                                 in_valid,
    input  rob_pkg::side_t                                       side,
    input  logic [rob_pkg::NUM_FACES-1:0][rob_pkg::Q_W-1:0]      t,
    input  logic [rob_pkg::CFG_W-1:0]                            size,
    output logic                                                 out_valid,
    output logic                                                 hit,
    output logic [rob_pkg::T_W-1:0]                              tmin,
    output logic [rob_pkg::T_W-1:0]                              tmax
);

    localparam int NF = rob_pkg::NUM_FACES;
    localparam int NA = rob_pkg::NUM_AXES;

    logic [2:0] valid_reg;

    logic                              cand_reg [NF];
    logic [rob_pkg::Q_W-1:0]           t1_reg   [NF];
    logic signed [rob_pkg::PLO_W-1:0]  plo_next [NF][2];
    logic signed [rob_pkg::PLO_W-1:0]  plo_reg  [NF][2];
    logic signed [rob_pkg::PHI_W-1:0]  phi_next [NF][2];
    logic signed [rob_pkg::PHI_W-1:0]  phi_reg  [NF][2];
    logic signed [rob_pkg::POS_W-1:0]  pos1_reg [NA];
    logic [rob_pkg::T_W-1:0]           tmin1_reg, tmax1_reg;

    logic signed [rob_pkg::U_W-1:0]    u        [NF][2];
    logic signed [rob_pkg::U_W-1:0]    lim      [NF][2];
    logic                              in_face  [NF][2];
    logic                              fv_reg   [NF];
    logic [rob_pkg::Q_W-1:0]           t2_reg   [NF];
    logic [rob_pkg::T_W-1:0]           tmin2_reg, tmax2_reg;

    logic                              hit_next, hit_reg;
    logic [rob_pkg::T_W-1:0]           tmin_next, tmax_next, tmin3_reg, tmax3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // crossing point on the two other axes, split products of dir and t
    for (genvar f = 0; f < NF; f++)
    begin : g_face
        for (genvar m = 0; m < 2; m++)
        begin : g_other
            localparam int AX = (f / 2 + 1 + m) % NA;

            assign plo_next[f][m] = rob_pkg::PLO_W'($signed(side.dir[AX]))
                * rob_pkg::PLO_W'($signed({1'b0, t[f][rob_pkg::T_LO_W-1:0]}));
            assign phi_next[f][m] = rob_pkg::PHI_W'($signed(side.dir[AX]))
                * rob_pkg::PHI_W'($signed({1'b0, t[f][rob_pkg::Q_W-1:rob_pkg::T_LO_W]}));

            assign u[f][m] = (rob_pkg::U_W'(pos1_reg[AX]) <<< rob_pkg::FRAC_SH)
                + (rob_pkg::U_W'(phi_reg[f][m]) <<< rob_pkg::T_LO_W)
                + rob_pkg::U_W'(plo_reg[f][m]);
            assign lim[f][m] = rob_pkg::U_W'($signed(
                    size[AX*rob_pkg::COORD_W +: rob_pkg::COORD_W])) <<< (2 * rob_pkg::FRAC_SH);
            assign in_face[f][m] = (u[f][m] > 0) && (u[f][m] < lim[f][m]);
        end
    end

    // widen the interval by every valid crossing
    always_comb
    begin
        hit_next  = 1'b0;
        tmin_next = tmin2_reg;
        tmax_next = tmax2_reg;
        for (int f = 0; f < NF; f++)
        begin
            if (fv_reg[f])
            begin
                hit_next = 1'b1;
                if ($signed(rob_pkg::T_W'(t2_reg[f])) < $signed(tmin_next))
                begin
                    tmin_next = rob_pkg::T_W'(t2_reg[f]);
                end
                if ($signed(rob_pkg::T_W'(t2_reg[f])) > $signed(tmax_next))
                begin
                    tmax_next = rob_pkg::T_W'(t2_reg[f]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int f = 0; f < NF; f++)
            begin
                cand_reg[f] <= side.elig[f] && (t[f] != '0);
                t1_reg[f]   <= t[f];
                fv_reg[f]   <= cand_reg[f] && in_face[f][0] && in_face[f][1];
                t2_reg[f]   <= t1_reg[f];
            end
            for (int k = 0; k < NA; k++)
            begin
                pos1_reg[k] <= $signed(side.pos[k]);
            end
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            tmin1_reg <= side.tmin;
            tmax1_reg <= side.tmax;
            tmin2_reg <= tmin1_reg;
            tmax2_reg <= tmax1_reg;
            hit_reg   <= hit_next;
            tmin3_reg <= tmin_next;
            tmax3_reg <= tmax_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign hit       = hit_reg;
    assign tmin      = tmin3_reg;
    assign tmax      = tmax3_reg;

endmodule

`default_nettype wire

FILE: design/ray_oriented_box_intersect.sv
`default_nettype none
// throughput: one item per cycle while the output buffer has room, set by the
// 32-stage pipelined dividers (one quotient bit per stage after the first, six of them
// in parallel) and the 4+3 other stages
// a two-item output buffer keeps accepting while results wait to be taken
// reset: rst_n asynchronous low clears valid bits and buffer; configuration registers take reset values

module ray_oriented_box_intersect (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [rob_pkg::COORD_W-1:0] ray_origin_x,
    input  logic signed [rob_pkg::COORD_W-1:0] ray_origin_y,
    input  logic signed [rob_pkg::COORD_W-1:0] ray_origin_z,
    input  logic signed [rob_pkg::VEC_W-1:0]   ray_dir_x,
    input  logic signed [rob_pkg::VEC_W-1:0]   ray_dir_y,
    input  logic signed [rob_pkg::VEC_W-1:0]   ray_dir_z,
    input  logic signed [rob_pkg::T_W-1:0]     tmin_in,
    input  logic signed [rob_pkg::T_W-1:0]     tmax_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic signed [rob_pkg::T_W-1:0]     tmin_out,
    output logic signed [rob_pkg::T_W-1:0]     tmax_out,
    input  logic                              cfg_we,
    input  logic [rob_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rob_pkg::CFG_W-1:0]          cfg_data
);

    localparam int NS = rob_pkg::DIV_STAGES;

    typedef struct packed {
        logic                     hit;
        logic [rob_pkg::T_W-1:0]  tmin;
        logic [rob_pkg::T_W-1:0]  tmax;
    } res_t;

    rob_pkg::cfg_t   cfg_reg;
    logic            advance;
    logic            proj_valid;
    rob_pkg::side_t  proj_side;
    rob_pkg::divop_t divop;
    rob_pkg::side_t  side_reg  [NS];
    logic [NS-1:0]   svalid_reg;
    logic [rob_pkg::NUM_FACES-1:0][rob_pkg::Q_W-1:0] quo;
    logic            chk_valid;
    res_t            chk_res;
    res_t            buf_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg, count_next;
    logic            push, pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.basis[0] <= rob_pkg::E1_RST;
            cfg_reg.basis[1] <= rob_pkg::E2_RST;
            cfg_reg.basis[2] <= rob_pkg::E3_RST;
            cfg_reg.origin   <= '0;
            cfg_reg.size     <= '0;
            cfg_reg.eps      <= rob_pkg::EPS_RST;
        end
        else if (cfg_we)
        begin
            case (rob_pkg::cfg_idx_t'(cfg_index))
                rob_pkg::CFG_E1:     cfg_reg.basis[0] <= cfg_data[rob_pkg::BASIS_W-1:0];
                rob_pkg::CFG_E2:     cfg_reg.basis[1] <= cfg_data[rob_pkg::BASIS_W-1:0];
                rob_pkg::CFG_E3:     cfg_reg.basis[2] <= cfg_data[rob_pkg::BASIS_W-1:0];
                rob_pkg::CFG_ORIGIN: cfg_reg.origin   <= cfg_data;
                rob_pkg::CFG_SIZE:   cfg_reg.size     <= cfg_data;
                rob_pkg::CFG_EPS:    cfg_reg.eps      <= cfg_data[rob_pkg::EPS_W-1:0];
                default:             ;
            endcase
        end
    end

    // whole pipeline moves while the output buffer has room
    assign advance  = (count_reg != 2'd2);
    assign in_stall = !advance;

    rob_project u_project (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (in_valid),
        .ray_origin ({ray_origin_z, ray_origin_y, ray_origin_x}),
        .ray_dir    ({ray_dir_z, ray_dir_y, ray_dir_x}),
        .tmin       (tmin_in),
        .tmax       (tmax_in),
        .cfg        (cfg_reg),
        .out_valid  (proj_valid),
        .side       (proj_side),
        .divop      (divop)
    );

    // one divider per face
    for (genvar f = 0; f < rob_pkg::NUM_FACES; f++)
    begin : g_div
        rob_div u_div (
            .clk (clk),
            .en  (advance),
            .num (divop.num[f]),
            .den (divop.den[f/2]),
            .quo (quo[f])
        );
    end

    // side data delay line matched to the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svalid_reg <= '0;
        end
        else if (advance)
        begin
            svalid_reg <= {svalid_reg[NS-2:0], proj_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= proj_side;
            for (int s = 1; s < NS; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    rob_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (svalid_reg[NS-1]),
        .side      (side_reg[NS-1]),
        .t         (quo),
        .size      (cfg_reg.size),
        .out_valid (chk_valid),
        .hit       (chk_res.hit),
        .tmin      (chk_res.tmin),
        .tmax      (chk_res.tmax)
    );

    // two-item output buffer
    assign push = advance && chk_valid;
    assign pop  = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= chk_res;
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign hit       = buf_reg[rd_ptr_reg].hit;
    assign tmin_out  = buf_reg[rd_ptr_reg].tmin;
    assign tmax_out  = buf_reg[rd_ptr_reg].tmax;

    // buffer never holds more than two items
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    // a held pipeline keeps its last stage
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(chk_valid) && $stable(chk_res))
        else $error("pipeline changed while held");

    // a full buffer drains before anything else is pushed
    a_full_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) && !pop |=> (count_reg == 2'd2) && $stable(wr_ptr_reg))
        else $error("full output buffer accepted an item");

endmodule

`default_nettype wire

FILE: test/tb_ray_oriented_box_intersect.sv
`timescale 1ns / 100ps

import rob_pkg::*;

// one ray item as driven into the block
typedef struct {
    logic signed [COORD_W-1:0] org[3];
    logic signed [VEC_W-1:0]   dir[3];
    logic signed [T_W-1:0]     tmin;
    logic signed [T_W-1:0]     tmax;
} ray_item_t;

// one expected intersection result
typedef struct {
    bit                    hit;
    logic signed [T_W-1:0] tmin;
    logic signed [T_W-1:0] tmax;
} box_hit_t;

class box_hit_scoreboard;
    logic [BASIS_W-1:0] basis[3];
    logic [CFG_W-1:0]   corner;
    logic [CFG_W-1:0]   sides;
    logic [EPS_W-1:0]   eps;
    box_hit_t           pending_hits[$];
    int                 errors;

    function new();
        basis[0] = E1_RST;
        basis[1] = E2_RST;
        basis[2] = E3_RST;
        corner   = '0;
        sides    = '0;
        eps      = EPS_RST;
        errors   = 0;
    endfunction

    // mirror of a register write
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_E1:     basis[0] = data[BASIS_W-1:0];
            CFG_E2:     basis[1] = data[BASIS_W-1:0];
            CFG_E3:     basis[2] = data[BASIS_W-1:0];
            CFG_ORIGIN: corner   = data;
            CFG_SIZE:   sides    = data;
            CFG_EPS:    eps      = data[EPS_W-1:0];
            default:    ;
        endcase
    endfunction

    // slab crossing prediction for an accepted ray
    function void note_ray(ray_item_t r);
        longint rel[3], rd[3], pos[3], dir[3], sz[3];
        longint c, p, d, ad, face, num, t, ua, ub, tmn, tmx, lim;
        int a, b;
        bit h;
        box_hit_t e;
        tmn = longint'(r.tmin);
        tmx = longint'(r.tmax);
        lim = longint'(eps) * 16384;
        h = 0;
        for (int i = 0; i < 3; i++)
        begin
            rel[i] = longint'(r.org[i]) - longint'($signed(corner[i*COORD_W +: COORD_W]));
            rd[i]  = longint'(r.dir[i]);
            sz[i]  = longint'($signed(sides[i*COORD_W +: COORD_W]));
        end
        for (int k = 0; k < 3; k++)
        begin
            p = 0;
            d = 0;
            for (int i = 0; i < 3; i++)
            begin
                c = longint'($signed(basis[k][i*VEC_W +: VEC_W]));
                p += c * rel[i];
                d += c * rd[i];
            end
            pos[k] = p;
            dir[k] = d;
        end
        for (int k = 0; k < 3; k++)
        begin
            d  = dir[k];
            ad = (d < 0) ? -d : d;
            if (ad <= lim || d == 0)
                continue;
            for (int f = 0; f < 2; f++)
            begin
                face = f ? sz[k] * 16384 : 0;
                num  = (face - pos[k]) * 16384;
                t    = num / d;
                if (t > 64'sd2147483647)
                    t = 64'sd2147483647;
                if (t < -64'sd2147483648)
                    t = -64'sd2147483648;
                if (t <= 0)
                    continue;
                a  = (k + 1) % 3;
                b  = (k + 2) % 3;
                ua = pos[a] * 16384 + dir[a] * t;
                ub = pos[b] * 16384 + dir[b] * t;
                if (!(ua > 0 && ua < sz[a] * 268435456))
                    continue;
                if (!(ub > 0 && ub < sz[b] * 268435456))
                    continue;
                h = 1;
                if (t < tmn)
                    tmn = t;
                if (t > tmx)
                    tmx = t;
            end
        end
        e.hit  = h;
        e.tmin = tmn[T_W-1:0];
        e.tmax = tmx[T_W-1:0];
        pending_hits.push_back(e);
    endfunction

    // compare a result against the oldest prediction
    function void check_result(bit h, logic signed [T_W-1:0] tmn, logic signed [T_W-1:0] tmx);
        box_hit_t e;
        if (pending_hits.size() == 0)
        begin
            $display("%0t: unexpected result hit=%0d tmin=%0d tmax=%0d", $time, h, tmn, tmx);
            errors++;
            return;
        end
        e = pending_hits.pop_front();
        if (h !== e.hit)
        begin
            $display("%0t: hit expected %0d actual %0d", $time, e.hit, h);
            errors++;
        end
        if (tmn !== e.tmin)
        begin
            $display("%0t: tmin_out expected %0d actual %0d", $time, e.tmin, tmn);
            errors++;
        end
        if (tmx !== e.tmax)
        begin
            $display("%0t: tmax_out expected %0d actual %0d", $time, e.tmax, tmx);
            errors++;
        end
    endfunction
endclass

module tb_ray_oriented_box_intersect;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int RAYS_PER_SET = 125;
    localparam int NUM_SETS     = 7;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] ray_origin_x, ray_origin_y, ray_origin_z;
    logic signed [VEC_W-1:0]   ray_dir_x, ray_dir_y, ray_dir_z;
    logic signed [T_W-1:0]     tmin_in, tmax_in;
    logic                      out_valid;
    logic                      out_stall;
    logic                      hit;
    logic signed [T_W-1:0]     tmin_out, tmax_out;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    box_hit_scoreboard sb;
    bit   quiet;
    bit   hold_req;
    int   hold_left;
    int   stall_left;
    int   cycles;
    logic signed [COORD_W-1:0] box_corner[3];
    int   box_span;

    ray_oriented_box_intersect DUT (.*);

    // clock
    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check and random stall bursts
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(hit, tmin_out, tmax_out);
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 0;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 14);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic [CFG_W-1:0] pack_coords(int x, int y, int z);
        logic [COORD_W-1:0] a, b, c;
        a = x[COORD_W-1:0];
        b = y[COORD_W-1:0];
        c = z[COORD_W-1:0];
        return {c, b, a};
    endfunction

    function automatic logic [CFG_W-1:0] pack_vec(int x, int y, int z);
        logic [VEC_W-1:0] a, b, c;
        a = x[VEC_W-1:0];
        b = y[VEC_W-1:0];
        c = z[VEC_W-1:0];
        return {15'h0, c, b, a};
    endfunction

    function automatic ray_item_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                           int tmn, int tmx);
        ray_item_t r;
        r.org[0] = ox[COORD_W-1:0];
        r.org[1] = oy[COORD_W-1:0];
        r.org[2] = oz[COORD_W-1:0];
        r.dir[0] = dx[VEC_W-1:0];
        r.dir[1] = dy[VEC_W-1:0];
        r.dir[2] = dz[VEC_W-1:0];
        r.tmin   = tmn;
        r.tmax   = tmx;
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // full box setting, spare indexes written with junk
    task automatic load_box(logic [CFG_W-1:0] e1, logic [CFG_W-1:0] e2, logic [CFG_W-1:0] e3,
                            logic [CFG_W-1:0] org, logic [CFG_W-1:0] sz, logic [CFG_W-1:0] ep);
        write_reg(CFG_E1, e1);
        write_reg(CFG_E2, e2);
        write_reg(CFG_E3, e3);
        write_reg(CFG_ORIGIN, org);
        write_reg(CFG_SIZE, sz);
        write_reg(CFG_EPS, ep);
        write_reg(CFG_SPARE_LO, CFG_W'({$urandom, $urandom}));
        write_reg(CFG_SPARE_HI, CFG_W'({$urandom, $urandom}));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // offer one item and wait for it to be taken
    task automatic send_ray(ray_item_t r);
        in_valid     <= 1'b1;
        ray_origin_x <= r.org[0];
        ray_origin_y <= r.org[1];
        ray_origin_z <= r.org[2];
        ray_dir_x    <= r.dir[0];
        ray_dir_y    <= r.dir[1];
        ray_dir_z    <= r.dir[2];
        tmin_in      <= r.tmin;
        tmax_in      <= r.tmax;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_ray(r);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // wait for all results, then let the pipeline drain
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_hits.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic int rand_unit_axis_comp(int sel, int idx, bit neg);
        return (sel == idx) ? (neg ? -16384 : 16384) : 0;
    endfunction

    // ray near the box corner with random direction, or plain noise
    function automatic ray_item_t random_ray();
        ray_item_t r;
        int o[3];
        int tmn, tmx;
        for (int i = 0; i < 3; i++)
            o[i] = int'(box_corner[i]) + $urandom_range(0, 4 * box_span) - 2 * box_span;
        case ($urandom_range(0, 3))
            0:
            begin
                tmn = $urandom;
                tmx = $urandom;
            end
            1:
            begin
                tmn = 0;
                tmx = 0;
            end
            default:
            begin
                tmn = 32'h7fff_ffff;
                tmx = 32'h8000_0000;
            end
        endcase
        if ($urandom_range(0, 4) == 0)
            r = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, tmn, tmx);
        else
            r = make_ray(o[0], o[1], o[2], $urandom, $urandom, $urandom, tmn, tmx);
        return r;
    endfunction

    task automatic random_setting(int set);
        int sel[3];
        bit neg[3];
        int sz[3];
        logic [CFG_W-1:0] e[3];
        logic [CFG_W-1:0] ep;
        for (int k = 0; k < 3; k++)
        begin
            sel[k] = (k + set) % 3;
            neg[k] = 1'($urandom_range(0, 1));
            sz[k]  = $urandom_range(256, 8192);
            box_corner[k] = COORD_W'($urandom_range(0, 400000) - 200000);
            e[k] = pack_vec(rand_unit_axis_comp(sel[k], 0, neg[k]),
                            rand_unit_axis_comp(sel[k], 1, neg[k]),
                            rand_unit_axis_comp(sel[k], 2, neg[k]));
        end
        box_span = 8192;
        ep = CFG_W'($urandom_range(0, 64));
        case (set)
            // fully random axis vectors
            2:
                for (int k = 0; k < 3; k++)
                    e[k] = CFG_W'({$urandom, $urandom});
            // extreme axis components, zero side on one axis
            3:
            begin
                e[0] = pack_vec(-32768, 32767, 0);
                e[1] = pack_vec(32767, 32767, -32768);
                e[2] = pack_vec(0, -32768, 32767);
                sz[1] = 0;
            end
            // negative side on the first axis, zero threshold
            4:
            begin
                sz[0] = -sz[0];
                ep = '0;
            end
            // largest threshold, so almost every axis counts as parallel
            5:
                ep = CFG_W'(15'h7fff);
            // corner at the coordinate extremes, huge sides
            6:
            begin
                box_corner[0] = COORD_W'(-1048576);
                box_corner[1] = COORD_W'(1048575);
                box_corner[2] = COORD_W'(-1048576);
                sz[0] = 1048575;
                sz[1] = 1048575;
                sz[2] = 1048575;
                box_span = 500000;
            end
            default: ;
        endcase
        load_box(e[0], e[1], e[2],
                 pack_coords(box_corner[0], box_corner[1], box_corner[2]),
                 pack_coords(sz[0], sz[1], sz[2]), ep);
    endtask

    // stimulus
    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        ray_origin_x = '0;
        ray_origin_y = '0;
        ray_origin_z = '0;
        ray_dir_x    = '0;
        ray_dir_y    = '0;
        ray_dir_z    = '0;
        tmin_in      = '0;
        tmax_in      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        quiet        = 0;
        hold_req     = 0;
        hold_left    = 0;
        stall_left   = 0;
        cycles       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset box has zero sides, so nothing can hit
        send_ray(make_ray(0, 0, 0, 16384, 16384, 16384, 32'h7fff_ffff, 32'h8000_0000));
        send_ray(make_ray(-1024, 100, 100, 16384, 0, 0, 0, 0));
        drain();

        // axis-aligned box, directed rays
        box_corner[0] = COORD_W'(1024);
        box_corner[1] = COORD_W'(2048);
        box_corner[2] = COORD_W'(-1024);
        box_span = 8192;
        load_box(CFG_W'(E1_RST), CFG_W'(E2_RST), CFG_W'(E3_RST), pack_coords(1024, 2048, -1024),
                 pack_coords(4096, 2048, 8192), CFG_W'(EPS_RST));
        // straight through along x
        send_ray(make_ray(0, 3072, 0, 16384, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
        // pointing away: negative t
        send_ray(make_ray(0, 3072, 0, -16384, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
        // start inside the box, only the far face ahead
        send_ray(make_ray(2048, 3072, 0, 0, 8192, 0, 0, 0));
        // zero direction
        send_ray(make_ray(0, 3072, 0, 0, 0, 0, 100, 200));
        // direction below the threshold
        send_ray(make_ray(0, 3072, 0, 1, 1, 1, 100, 200));
        // grazing the face edge: crossing point not strictly inside
        send_ray(make_ray(0, 2048, 0, 16384, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
        // inverted interval
        send_ray(make_ray(0, 3072, 0, 16384, 0, 0, 5000, -5000));
        // diagonal hit
        send_ray(make_ray(0, 1024, -2048, 16384, 16384, 16384, 0, 0));
        // field extremes
        send_ray(make_ray(1048575, 1048575, 1048575, 32767, 32767, 32767,
                          32'h7fff_ffff, 32'h7fff_ffff));
        send_ray(make_ray(-1048576, -1048576, -1048576, -32768, -32768, -32768,
                          32'h8000_0000, 32'h8000_0000));
        send_ray(make_ray(-1048576, 3072, 0, 32767, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
        send_ray(make_ray(1048575, 3072, 0, -32768, 0, 0, 0, 32'h8000_0000));
        // tiny direction: quotient saturates
        send_ray(make_ray(-1048576, 3072, 0, 2, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
        drain();

        // random settings
        for (int set = 0; set < NUM_SETS; set++)
        begin
            random_setting(set);
            if (set == 1)
                hold_req = 1;
            if (set == NUM_SETS - 1)
                quiet = 1;
            for (int n = 0; n < RAYS_PER_SET; n++)
                send_ray(random_ray());
            drain();
        end

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/rob_pkg.sv
design/rob_project.sv
design/rob_div.sv
design/rob_check.sv
design/ray_oriented_box_intersect.sv
test/tb_ray_oriented_box_intersect.sv
